// ===== rtl/scrgb_pkg.sv =====
// Shared types, constants and elaboration-time tables for the scRGB to sRGB encoder.
// Used by every module of the block; depends on nothing else.
package scrgb_pkg;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int CNT_W = 23;
	localparam int PEAK_W = 15;
	localparam int LUMA_W = 48;
	localparam int LIN_STEPS = 10;

	typedef logic [16:0] q16_t;
	typedef q16_t thr_tab_t [256];
	typedef q16_t lin_tab_t [LIN_STEPS + 1];

	// Rec.709 luminance weights in Q16.
	localparam logic signed [17:0] LUMA_C_RED = 18'sd13933;
	localparam logic signed [17:0] LUMA_C_GREEN = 18'sd46871;
	localparam logic signed [17:0] LUMA_C_BLUE = 18'sd4732;

	// Largest Q16 value that still uses the linear segment of the sRGB curve.
	localparam q16_t LIN_LIMIT = 17'd205;
	localparam q16_t Q16_ONE = 17'h10000;

	// Entry v is the smallest Q16 value x that encodes to at least byte v on the
	// power segment, found exactly: x^5 * 10761^12 >= (40v+541)^12 * 2^80.
	function automatic thr_tab_t srgb_thr_tab();
		thr_tab_t tab;
		logic [255:0] k12;
		logic [255:0] rhs;
		logic [255:0] lhs;
		int v;
		int i;
		int lo;
		int hi;
		int mid;
		k12 = 256'd1;
		for (i = 0; i < 12; i++) k12 = k12 * 256'd10761;
		for (v = 0; v < 256; v++) begin
			rhs = 256'd1;
			for (i = 0; i < 12; i++) rhs = rhs * 256'(40 * v + 541);
			rhs = rhs << 80;
			lo = 0;
			hi = 65536;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				lhs = 256'd1;
				for (i = 0; i < 5; i++) lhs = lhs * 256'(mid);
				lhs = lhs * k12;
				if (lhs >= rhs) hi = mid;
				else lo = mid + 1;
			end
			tab[v] = 17'(lo);
		end
		return tab;
	endfunction

	// Entry v is the smallest Q16 value with 32946*x + 327680 >= 655360*v.
	function automatic lin_tab_t srgb_lin_tab();
		lin_tab_t tab;
		int v;
		tab[0] = '0;
		for (v = 1; v <= LIN_STEPS; v++)
			tab[v] = 17'((655360 * v - 327680 + 32945) / 32946);
		return tab;
	endfunction

	localparam thr_tab_t SRGB_THR = srgb_thr_tab();
	localparam lin_tab_t SRGB_LIN = srgb_lin_tab();

	// One classified pixel as it waits between the front and the back.
	typedef struct packed {
		logic signed [15:0] red;
		logic signed [15:0] green;
		logic signed [15:0] blue;
		logic [2:0][14:0] pos;    // index 0 red, 1 green, 2 blue; clamped at zero
		logic [14:0] mpos;
		logic signed [15:0] mx;
		logic neg;
		logic fs;
	} item_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic srch_step;
	} lane_ctl_t;

endpackage

// ===== rtl/scrgb_front.sv =====
// Input side: takes pixel beats and classifies them for the queue.
// Depends on scrgb_pkg.
module scrgb_front import scrgb_pkg::*; (
	input  logic               pix_valid,
	output logic               pix_ready,
	input  logic signed [15:0] red,
	input  logic signed [15:0] green,
	input  logic signed [15:0] blue,
	input  logic               frame_start,
	input  logic               q_full,
	output logic               push,
	output item_t              push_item
);

	logic signed [15:0] mx_rg;
	logic signed [15:0] mx;
	logic [2:0][14:0] pos;
	logic [14:0] m_rg;

	assign pix_ready = !q_full;
	assign push = pix_valid && !q_full;

	always_comb begin
		mx_rg = (green > red) ? green : red;
		mx = (blue > mx_rg) ? blue : mx_rg;
		pos[0] = red[15] ? 15'd0 : red[14:0];
		pos[1] = green[15] ? 15'd0 : green[14:0];
		pos[2] = blue[15] ? 15'd0 : blue[14:0];
		m_rg = (pos[1] > pos[0]) ? pos[1] : pos[0];
		push_item.red = red;
		push_item.green = green;
		push_item.blue = blue;
		push_item.pos = pos;
		push_item.mpos = (pos[2] > m_rg) ? pos[2] : m_rg;
		push_item.mx = mx;
		push_item.neg = red[15] || green[15] || blue[15];
		push_item.fs = frame_start;
	end

endmodule

// ===== rtl/scrgb_fifo.sv =====
// Short queue of classified pixels between the front and the back.
// Depends on scrgb_pkg.
module scrgb_fifo import scrgb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	item_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0] cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/scrgb_lane.sv =====
// One channel lane: bit-serial Q16 divider followed by a table search for the sRGB byte.
// Depends on scrgb_pkg for the threshold tables.
module scrgb_lane import scrgb_pkg::*; (
	input  logic        clk,
	input  lane_ctl_t   ctl,
	input  logic [14:0] numer,
	input  logic [16:0] divisor,
	input  logic        full,
	output logic [7:0]  code
);

	logic [16:0] div_q;
	logic [16:0] rem_q;
	logic [15:0] quo_q;
	logic        full_q;
	logic [7:0]  lo_q;
	logic [7:0]  hi_q;

	logic [17:0] r2;
	logic [17:0] diff;
	logic        ge;
	logic [7:0]  mid;
	q16_t        x;
	logic        take;
	logic [3:0]  lin_code;

	always_comb begin
		r2 = {rem_q, 1'b0};
		diff = r2 - {1'b0, div_q};
		ge = (r2 >= {1'b0, div_q});
		mid = 8'((9'(lo_q) + 9'(hi_q) + 9'd1) >> 1);
		x = full_q ? Q16_ONE : {1'b0, quo_q};
		take = (SRGB_THR[mid] <= x);
		lin_code = '0;
		for (int i = 1; i <= LIN_STEPS; i++)
			lin_code = lin_code + 4'(x >= SRGB_LIN[i]);
	end

	// The numerator is always below the divisor unless the lane is forced to full
	// scale, so the remainder starts at the numerator and sixteen steps give the Q16 ratio.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			div_q <= divisor;
			rem_q <= {2'b00, numer};
			quo_q <= '0;
			full_q <= full;
			lo_q <= '0;
			hi_q <= '1;
		end else if (ctl.div_step) begin
			rem_q <= ge ? diff[16:0] : r2[16:0];
			quo_q <= {quo_q[14:0], ge};
		end else if (ctl.srch_step) begin
			if (take) lo_q <= mid;
			else hi_q <= mid - 8'd1;
		end
	end

	always_comb begin
		priority if (full_q) code = 8'd255;
		else if (quo_q == '0) code = 8'd0;
		else if ({1'b0, quo_q} <= LIN_LIMIT) code = {4'd0, lin_code};
		else code = lo_q;
	end

endmodule

// ===== rtl/scrgb_back.sv =====
// Back end: pops classified pixels, runs the six channel lanes, keeps the frame
// statistics and holds the result beat. Depends on scrgb_pkg and scrgb_lane.
module scrgb_back import scrgb_pkg::*; #(
	parameter int MAX_PIXELS = 4194304
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [16:0]              scale,
	input  logic                     q_valid,
	input  item_t                    q_item,
	output logic                     q_pop,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [7:0]               sdr_blue,
	output logic [7:0]               sdr_green,
	output logic [7:0]               sdr_red,
	output logic [7:0]               mapped_blue,
	output logic [7:0]               mapped_green,
	output logic [7:0]               mapped_red,
	output logic [CNT_W-1:0]         negative_pixels,
	output logic [CNT_W-1:0]         bright_pixels,
	output logic [PEAK_W-1:0]        peak_component,
	output logic signed [LUMA_W-1:0] luma_total
);

	localparam logic [CNT_W-1:0] CNT_TOP = (MAX_PIXELS < (2**CNT_W - 1)) ?
		CNT_W'(MAX_PIXELS) : {CNT_W{1'b1}};
	localparam logic signed [LUMA_W-1:0] LUMA_MAX = {1'b0, {(LUMA_W-1){1'b1}}};
	localparam logic signed [LUMA_W-1:0] LUMA_MIN = {1'b1, {(LUMA_W-1){1'b0}}};
	localparam logic [4:0] LAST_STEP = 5'd23;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

	state_t state_q;
	logic [4:0] step_q;
	logic [CNT_W-1:0] neg_q;
	logic [CNT_W-1:0] bright_q;
	logic [PEAK_W-1:0] peak_q;
	logic signed [LUMA_W-1:0] acc_q;
	logic signed [33:0] lsum_q;
	logic signed [15:0] red_q;
	logic signed [15:0] green_q;
	logic signed [15:0] blue_q;
	logic res_valid_q;

	logic [16:0] s_eff;
	logic [16:0] map_div;
	lane_ctl_t ctl;
	logic [2:0][7:0] clip_code;
	logic [2:0][7:0] map_code;
	logic out_free;

	logic [CNT_W-1:0] neg_base;
	logic [CNT_W-1:0] bright_base;
	logic [PEAK_W-1:0] peak_base;
	logic signed [15:0] comp;
	logic signed [17:0] coef;
	logic signed [33:0] prod;
	logic signed [33:0] lround;
	logic signed [17:0] lum;
	logic signed [LUMA_W:0] acc_sum;

	assign s_eff = (scale == '0) ? 17'd1 : scale;
	assign map_div = s_eff + {2'b00, q_item.mpos};
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign out_free = !res_valid_q || res_ready;

	always_comb begin
		ctl.load = q_pop;
		ctl.div_step = (state_q == ST_RUN) && !step_q[4];
		ctl.srch_step = (state_q == ST_RUN) && step_q[4];
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		scrgb_lane u_clip (
			.clk    (clk),
			.ctl    (ctl),
			.numer  (q_item.pos[i]),
			.divisor(s_eff),
			.full   ({2'b00, q_item.pos[i]} >= s_eff),
			.code   (clip_code[i])
		);
		scrgb_lane u_map (
			.clk    (clk),
			.ctl    (ctl),
			.numer  (q_item.pos[i]),
			.divisor(map_div),
			.full   (1'b0),
			.code   (map_code[i])
		);
	end

	always_comb begin
		neg_base = q_item.fs ? '0 : neg_q;
		bright_base = q_item.fs ? '0 : bright_q;
		peak_base = q_item.fs ? '0 : peak_q;
		unique case (step_q[1:0])
			2'd0: begin
				comp = red_q;
				coef = LUMA_C_RED;
			end
			2'd1: begin
				comp = green_q;
				coef = LUMA_C_GREEN;
			end
			default: begin
				comp = blue_q;
				coef = LUMA_C_BLUE;
			end
		endcase
		prod = 34'(comp * coef);
		lround = lsum_q + 34'sd32768;
		lum = 18'(lround >>> 16);
		acc_sum = (LUMA_W+1)'(acc_q) + (LUMA_W+1)'(lum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			neg_q <= '0;
			bright_q <= '0;
			peak_q <= '0;
			acc_q <= '0;
			lsum_q <= '0;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
			res_valid_q <= 1'b0;
			sdr_blue <= '0;
			sdr_green <= '0;
			sdr_red <= '0;
			mapped_blue <= '0;
			mapped_green <= '0;
			mapped_red <= '0;
			negative_pixels <= '0;
			bright_pixels <= '0;
			peak_component <= '0;
			luma_total <= '0;
		end else begin
			if (state_q == ST_HOLD && out_free) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_RUN;
						step_q <= '0;
						red_q <= q_item.red;
						green_q <= q_item.green;
						blue_q <= q_item.blue;
						lsum_q <= '0;
						if (q_item.fs) acc_q <= '0;
						neg_q <= (q_item.neg && neg_base < CNT_TOP) ? neg_base + 1'b1 : neg_base;
						bright_q <= ((18'(q_item.mx) > $signed({1'b0, scale})) &&
							bright_base < CNT_TOP) ? bright_base + 1'b1 : bright_base;
						peak_q <= (!q_item.mx[15] && q_item.mx[14:0] > peak_base) ?
							q_item.mx[14:0] : peak_base;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 5'd1;
					// Luminance is summed over the first three steps and folded in on the fourth.
					if (step_q < 5'd3) lsum_q <= lsum_q + prod;
					else if (step_q == 5'd3) begin
						if (acc_sum[LUMA_W] != acc_sum[LUMA_W-1])
							acc_q <= lum[17] ? LUMA_MIN : LUMA_MAX;
						else
							acc_q <= acc_sum[LUMA_W-1:0];
					end
					if (step_q == LAST_STEP) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						sdr_blue <= clip_code[2];
						sdr_green <= clip_code[1];
						sdr_red <= clip_code[0];
						mapped_blue <= map_code[2];
						mapped_green <= map_code[1];
						mapped_red <= map_code[0];
						negative_pixels <= neg_q;
						bright_pixels <= bright_q;
						peak_component <= peak_q;
						luma_total <= acc_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;

	a_peak_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(peak_q < $past(peak_q)) |-> ($past(q_pop) && $past(q_item.fs)))
		else $error("peak register fell without a frame start");

	a_neg_step: assert property (@(posedge clk) disable iff (!arst_n)
		(neg_q > $past(neg_q)) |-> (neg_q == $past(neg_q) + 1'b1))
		else $error("negative count advanced by more than one");

	a_cnt_top: assert property (@(posedge clk) disable iff (!arst_n)
		(neg_q <= CNT_TOP) && (bright_q <= CNT_TOP))
		else $error("pixel counter passed its limit");

	a_hold_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD && res_valid_q && !res_ready) |=> (state_q == ST_HOLD))
		else $error("result left the lanes while the output beat was still pending");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_RUN && step_q == '0))
		else $error("lane sequence did not restart after a pop");

endmodule

// ===== rtl/scrgb_to_srgb_tonemap_stats.sv =====
// Top level of the scRGB to sRGB encoder with Reinhard tone map and frame statistics.
// Depends on scrgb_pkg, scrgb_front, scrgb_fifo and scrgb_back.
//
// Each pixel beat carries signed Q4.12 linear red, green and blue plus a frame_start
// flag; each result beat carries clipped and tone-mapped sRGB bytes in BGR order and
// the frame statistics as they stand after that pixel. In the back end a pixel is popped,
// then each of the six channel lanes runs its bit-serial divider and then its sRGB
// table search, and the result is handed off from a hold state that waits for the output.
// A two-entry queue lets the input take pixels ahead while the back end works and while
// a finished result waits at the output. sdr_scale is written with sdr_scale_we; a white
// level of zero is treated as one by the dividers, but the bright count uses the raw value.
module scrgb_to_srgb_tonemap_stats import scrgb_pkg::*; #(
	parameter int MAX_PIXELS = 4194304,
	parameter int FRAC_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sdr_scale_we,
	input  logic [15:0]              sdr_scale_wdata,
	input  logic                     pix_valid,
	output logic                     pix_ready,
	input  logic signed [15:0]       red,
	input  logic signed [15:0]       green,
	input  logic signed [15:0]       blue,
	input  logic                     frame_start,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [7:0]               sdr_blue,
	output logic [7:0]               sdr_green,
	output logic [7:0]               sdr_red,
	output logic [7:0]               mapped_blue,
	output logic [7:0]               mapped_green,
	output logic [7:0]               mapped_red,
	output logic [CNT_W-1:0]         negative_pixels,
	output logic [CNT_W-1:0]         bright_pixels,
	output logic [PEAK_W-1:0]        peak_component,
	output logic signed [LUMA_W-1:0] luma_total
);

	logic [16:0] scale_q;
	logic q_full;
	logic push;
	item_t push_item;
	logic q_pop;
	logic q_valid;
	item_t q_item;

	// The reset white level can reach 2^16 at the widest fraction setting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scale_q <= 17'(1 << FRAC_BITS);
		else if (sdr_scale_we) scale_q <= {1'b0, sdr_scale_wdata};
	end

	scrgb_front u_front (
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.frame_start(frame_start),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	scrgb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_item (q_item)
	);

	scrgb_back #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.scale          (scale_q),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.sdr_blue       (sdr_blue),
		.sdr_green      (sdr_green),
		.sdr_red        (sdr_red),
		.mapped_blue    (mapped_blue),
		.mapped_green   (mapped_green),
		.mapped_red     (mapped_red),
		.negative_pixels(negative_pixels),
		.bright_pixels  (bright_pixels),
		.peak_component (peak_component),
		.luma_total     (luma_total)
	);

endmodule

// ===== dv/scrgb_to_srgb_tonemap_stats_tb.sv =====
// Testbench for scrgb_to_srgb_tonemap_stats: a directed table, then random pixel streams
// under several white levels and idling patterns, checked against an in-bench encoder model.
// Depends on scrgb_pkg and the RTL of the block only.
module scrgb_to_srgb_tonemap_stats_tb;
	import scrgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 210;
	localparam int PHASES = 8;
	localparam int DIRECTED_ROWS = 16;
	localparam longint CNT_TOP = 4194304;
	localparam longint LUMA_MAX = 64'sh7FFFFFFFFFFF;
	localparam longint LUMA_MIN = -LUMA_MAX - 1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	typedef struct packed {
		logic [7:0] sb;
		logic [7:0] sg;
		logic [7:0] sr;
		logic [7:0] mb;
		logic [7:0] mg;
		logic [7:0] mr;
		logic [CNT_W-1:0] neg;
		logic [CNT_W-1:0] bri;
		logic [PEAK_W-1:0] peak;
		logic [LUMA_W-1:0] luma;
	} pixel_out_t;

	typedef struct {
		logic signed [15:0] r;
		logic signed [15:0] g;
		logic signed [15:0] b;
		bit fs;
		bit typed;
		pixel_out_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic sdr_scale_we;
	logic [15:0] sdr_scale_wdata;
	logic pix_valid;
	logic pix_ready;
	logic signed [15:0] red;
	logic signed [15:0] green;
	logic signed [15:0] blue;
	logic frame_start;
	logic res_valid;
	logic res_ready;
	pixel_out_t got;

	scrgb_to_srgb_tonemap_stats DUT (
		.clk(clk), .arst_n(arst_n),
		.sdr_scale_we(sdr_scale_we), .sdr_scale_wdata(sdr_scale_wdata),
		.pix_valid(pix_valid), .pix_ready(pix_ready),
		.red(red), .green(green), .blue(blue), .frame_start(frame_start),
		.res_valid(res_valid), .res_ready(res_ready),
		.sdr_blue(got.sb), .sdr_green(got.sg), .sdr_red(got.sr),
		.mapped_blue(got.mb), .mapped_green(got.mg), .mapped_red(got.mr),
		.negative_pixels(got.neg), .bright_pixels(got.bri),
		.peak_component(got.peak), .luma_total(got.luma)
	);

	// Encoder model state.
	longint white_level;
	longint neg_count;
	longint bright_count;
	longint peak_val;
	longint luma_sum;

	pixel_out_t pending_px[$];
	idle_mode_e idle_mode;
	int errors = 0;
	int quiet_cycles = 0;
	logic [255:0] k12;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Exact sRGB encode of a Q16 value: linear segment near black, power segment
	// resolved by a binary search on the integer form of the threshold test.
	function automatic logic [7:0] srgb_encode(input longint x);
		logic [255:0] lhs;
		logic [255:0] rhs;
		int lo;
		int hi;
		int mid;
		int i;
		if (x == 0) return 8'd0;
		if (x >= 65536) return 8'd255;
		if (x * 10000000 <= 64'd31308 * 65536) return 8'((32946 * x + 327680) / 655360);
		lhs = 256'd1;
		for (i = 0; i < 5; i++) lhs = lhs * 256'(x);
		lhs = lhs * k12;
		lo = 0;
		hi = 255;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			rhs = 256'd1;
			for (i = 0; i < 12; i++) rhs = rhs * 256'(40 * mid + 541);
			rhs = rhs << 80;
			if (rhs <= lhs) lo = mid;
			else hi = mid - 1;
		end
		return 8'(lo);
	endfunction

	function automatic pixel_out_t encode_pixel(input logic signed [15:0] r,
			input logic signed [15:0] g, input logic signed [15:0] b, input bit fs);
		pixel_out_t o;
		longint c[3];
		longint pos[3];
		longint mpos;
		longint s;
		longint mx;
		longint lum;
		longint d;
		longint t;
		logic [7:0] sdr_b[3];
		logic [7:0] map_b[3];
		int i;
		c[0] = r;
		c[1] = g;
		c[2] = b;
		if (fs) begin
			neg_count = 0;
			bright_count = 0;
			peak_val = 0;
			luma_sum = 0;
		end
		s = (white_level != 0) ? white_level : 1;
		mx = c[0];
		for (i = 1; i < 3; i++) if (c[i] > mx) mx = c[i];
		if ((c[0] < 0 || c[1] < 0 || c[2] < 0) && neg_count < CNT_TOP) neg_count++;
		// The bright test uses the raw register, so a zero white level counts any positive.
		if (mx > white_level && bright_count < CNT_TOP) bright_count++;
		if (mx > 0 && mx > peak_val) peak_val = mx;
		lum = (13933 * c[0] + 46871 * c[1] + 4732 * c[2] + 32768) >>> 16;
		if (lum > 0 && luma_sum > LUMA_MAX - lum) luma_sum = LUMA_MAX;
		else if (lum < 0 && luma_sum < LUMA_MIN - lum) luma_sum = LUMA_MIN;
		else luma_sum += lum;
		mpos = 0;
		for (i = 0; i < 3; i++) begin
			pos[i] = (c[i] > 0) ? c[i] : 0;
			if (pos[i] > mpos) mpos = pos[i];
		end
		for (i = 0; i < 3; i++) begin
			d = pos[2 - i] * 65536 / s;
			t = pos[2 - i] * 65536 / (s + mpos);
			if (d > 65536) d = 65536;
			sdr_b[i] = srgb_encode(d);
			map_b[i] = srgb_encode(t);
		end
		o.sb = sdr_b[0];
		o.sg = sdr_b[1];
		o.sr = sdr_b[2];
		o.mb = map_b[0];
		o.mg = map_b[1];
		o.mr = map_b[2];
		o.neg = CNT_W'(neg_count);
		o.bri = CNT_W'(bright_count);
		o.peak = PEAK_W'(peak_val);
		o.luma = LUMA_W'(luma_sum);
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
		if (want !== seen) begin
			$error("%s: expected %0h, got %0h", name, want, seen);
			errors++;
		end
	endtask

	// Result side: ready is driven at the edge, the beat is checked at the falling edge
	// where both sides are stable.
	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: res_ready <= ($urandom_range(99) >= 54);
			IDLE_BOTH: res_ready <= ($urandom_range(99) >= 24);
			default: res_ready <= 1'b1;
		endcase
	end

	always @(negedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_px.size() == 0) begin
				$error("result beat with no pixel outstanding");
				errors++;
			end else begin
				pixel_out_t w;
				w = pending_px.pop_front();
				check_field("sdr_blue", w.sb, got.sb);
				check_field("sdr_green", w.sg, got.sg);
				check_field("sdr_red", w.sr, got.sr);
				check_field("mapped_blue", w.mb, got.mb);
				check_field("mapped_green", w.mg, got.mg);
				check_field("mapped_red", w.mr, got.mr);
				check_field("negative_pixels", w.neg, got.neg);
				check_field("bright_pixels", w.bri, got.bri);
				check_field("peak_component", w.peak, got.peak);
				check_field("luma_total", w.luma, got.luma);
			end
		end
		if ((pix_valid && pix_ready) || (res_valid && res_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_pixel(input logic signed [15:0] r, input logic signed [15:0] g,
			input logic signed [15:0] b, input bit fs, input bit typed, input pixel_out_t want);
		int pct;
		bit taken;
		pixel_out_t model;
		pct = (idle_mode == IDLE_SENDER) ? 54 : (idle_mode == IDLE_BOTH) ? 24 : 0;
		if (pct != 0 && $urandom_range(99) < pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < pct) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		frame_start <= fs;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = pix_ready;
			if (taken) begin
				model = encode_pixel(r, g, b, fs);
				pending_px = {pending_px, (typed ? want : model)};
			end
			@(posedge clk);
		end
	endtask

	task automatic set_white(input logic [15:0] v);
		pix_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sdr_scale_we <= 1'b1;
		sdr_scale_wdata <= v;
		@(posedge clk);
		sdr_scale_we <= 1'b0;
		white_level = v;
	endtask

	function automatic logic signed [15:0] rand_channel();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'sh7FFF - 16'($urandom_range(3));
			2: return -16'sd32768 + 16'($urandom_range(3));
			3: return 16'($urandom_range(64));
			4: return -16'($urandom_range(2048));
			default: return 16'(white_level) + 16'($urandom_range(64)) - 16'sd32;
		endcase
	endfunction

	stim_row_t rows[DIRECTED_ROWS];
	logic [15:0] white_plan[PHASES];

	initial begin
		pixel_out_t none;
		int p;
		int n;
		int i;
		none = '0;
		idle_mode = IDLE_NONE;
		k12 = 256'd1;
		for (i = 0; i < 12; i++) k12 = k12 * 256'd10761;
		white_level = 4096;
		neg_count = 0;
		bright_count = 0;
		peak_val = 0;
		luma_sum = 0;
		arst_n = 1'b0;
		sdr_scale_we = 1'b0;
		sdr_scale_wdata = '0;
		pix_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		frame_start = 1'b0;

		rows[0] = '{0, 0, 0, 1, 1, none};
		// All channels at the negative extreme: black bytes, one negative pixel,
		// luminance of exactly -32768.
		rows[1] = '{-16'sd32768, -16'sd32768, -16'sd32768, 0, 1,
			'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 23'd1, 23'd0, 15'd0, -48'sd32768}};
		rows[2] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, none};
		rows[3] = '{16'sd4096, 0, 0, 0, 0, none};
		rows[4] = '{0, 16'sd4096, 0, 0, 0, none};
		rows[5] = '{0, 0, 16'sd4096, 0, 0, none};
		rows[6] = '{16'sd4097, 16'sd4096, 0, 0, 0, none};
		rows[7] = '{16'sd12, 16'sd13, 16'sd1, 0, 0, none};
		rows[8] = '{16'sd14, 16'sd0, 16'sd200, 1, 0, none};
		rows[9] = '{16'sh7FFF, -16'sd32768, 0, 0, 0, none};
		rows[10] = '{-16'sd1, 16'sd1, 0, 0, 0, none};
		rows[11] = '{16'sd2048, 16'sd1024, 16'sd512, 0, 0, none};
		rows[12] = '{16'sd100, 16'sd30000, 16'sd5, 1, 0, none};
		rows[13] = '{-16'sd5, -16'sd7, 16'sd8192, 0, 0, none};
		rows[14] = '{16'sd4095, 16'sd4095, 16'sd4095, 0, 0, none};
		rows[15] = '{16'sh5555, 16'shAAAA, 16'sh2AAA, 0, 0, none};

		white_plan = '{16'd1, 16'd65535, 16'd0, 16'd2048, 16'($urandom_range(1, 65535)),
			16'($urandom_range(100, 8000)), 16'($urandom_range(1, 65535)), 16'd4096};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++)
			send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].fs, rows[i].typed, rows[i].want);

		for (p = 0; p < PHASES; p++) begin
			set_white(white_plan[p]);
			idle_mode = idle_mode_e'(p % 4);
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Long stretches per frame so the statistics build up between clears.
				send_pixel(rand_channel(), rand_channel(), rand_channel(),
					($urandom_range(49) == 0), 0, none);
			end
		end

		pix_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/scrgb_pkg.sv
rtl/scrgb_front.sv
rtl/scrgb_fifo.sv
rtl/scrgb_lane.sv
rtl/scrgb_back.sv
rtl/scrgb_to_srgb_tonemap_stats.sv
dv/scrgb_to_srgb_tonemap_stats_tb.sv
